// ===== design/tcce_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tcce_pkg;

  // geometry of the cursor and the screen
  localparam int POS_W         = 12;
  localparam int SUM_W         = POS_W + 1;
  localparam int GLYPH_WIDTH   = 8;
  localparam int LINE_HEIGHT   = 16;
  localparam int TAB_STEP      = 4 * GLYPH_WIDTH;
  localparam int BOTTOM_MARGIN = 8;

  // width / 3 as (width * 2731) >> 13, exact for every 12-bit width
  localparam int PROD_W      = 2 * POS_W;
  localparam int THIRD_SHIFT = 13;
  localparam logic [PROD_W-1:0] THIRD_MUL = PROD_W'(2731);

  // remainder unit: one quotient bit per cycle over the widest dividend
  localparam int DIV_CNT_W = 4;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(SUM_W - 1);

  // character codes
  localparam logic [7:0] CHAR_BS    = 8'd8;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_NL    = 8'd10;
  localparam logic [7:0] CHAR_SPACE = 8'd32;

  // configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FORE_COLOR    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BACK_COLOR    = 2'd3;

  // register reset values
  localparam logic [POS_W-1:0]      WIDTH_RESET  = 12'd640;
  localparam logic [POS_W-1:0]      HEIGHT_RESET = 12'd480;
  localparam logic [CFG_DATA_W-1:0] FORE_RESET   = 24'hFFFFFF;
  localparam logic [CFG_DATA_W-1:0] BACK_RESET   = 24'h000000;

  typedef struct packed {
    logic [7:0] char_code;
    logic       message_start;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0]      draw_x;
    logic [POS_W-1:0]      draw_y;
    logic [7:0]            glyph;
    logic [CFG_DATA_W-1:0] fore_color;
    logic [CFG_DATA_W-1:0] back_color;
  } out_item_t;

endpackage

`default_nettype wire

// ===== design/text_console_cursor_engine_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel | direction | handshake            | payload
// --------+-----------+----------------------+-------------------------------
// in      | in        | in_valid / in_stall  | in_data  (char_code, message_start)
// out     | out       | out_valid / out_stall| out_data (draw_x, draw_y, glyph, colors)
// cfg     | in        | cfg_we               | cfg_index, cfg_data
//
// one character per cycle unless stalled: cursor update and draw transaction form in
// the accept cycle, land in cursor and output registers; a draw shows on out next cycle
// a wrap reaching twice its limit (cursor left outside a shrunk screen, or a tiny
// screen) runs the bit-serial remainder unit, holding in_stall until it writes the cursor
// in_stall also rises while the output register is full and out is stalled
// rst (synchronous) zeroes the cursor and loads the register defaults

module text_console_cursor_engine_top (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        in_valid,
  output logic                       in_stall,
  input  wire tcce_pkg::in_item_t    in_data,
  output logic                       out_valid,
  input  wire                        out_stall,
  output tcce_pkg::out_item_t        out_data,
  input  wire                        cfg_we,
  input  wire [tcce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [tcce_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tcce_pkg::*;

  // configuration registers
  logic [POS_W-1:0]      screen_width;
  logic [POS_W-1:0]      screen_height;
  logic [CFG_DATA_W-1:0] fore_color_reg;
  logic [CFG_DATA_W-1:0] back_color_reg;

  // cursor state
  logic [POS_W-1:0] cursor_x;
  logic [POS_W-1:0] cursor_y;
  logic [POS_W-1:0] line_start_x;

  // remainder unit
  logic                 div_busy;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [SUM_W-1:0]     div_num;
  logic [POS_W-1:0]     div_rem;
  logic [POS_W-1:0]     div_mod;
  logic                 div_to_y;
  logic [SUM_W-1:0]     div_trial;
  logic [SUM_W-1:0]     div_rem_next;

  logic accept;

  // derived screen values
  logic [PROD_W-1:0] third_prod;
  logic [POS_W-1:0]  third;
  logic [POS_W-1:0]  limit;
  logic [SUM_W-1:0]  width13;
  logic [SUM_W-1:0]  limit13;

  // per-character datapath
  logic [POS_W-1:0] lsx_eff;
  logic [SUM_W-1:0] y_nl;
  logic [SUM_W-1:0] shift_nl;
  logic [POS_W-1:0] x_nl;
  logic [SUM_W-1:0] x_adv;
  logic             col_wrap;
  logic [SUM_W-1:0] y_gl;
  logic [POS_W-1:0] x_gl;
  logic [POS_W-1:0] x_bs;
  logic             emit;
  out_item_t        out_next;
  logic [POS_W-1:0] x_new;
  logic [POS_W-1:0] y_new;

  // wrap remainder request
  logic             mod_en;
  logic             mod_to_y;
  logic [SUM_W-1:0] mod_a;
  logic [POS_W-1:0] mod_m;
  logic [SUM_W-1:0] mod_m13;
  logic [SUM_W-1:0] mod_diff;
  logic             mod_fast;
  logic [POS_W-1:0] mod_res;
  logic [POS_W-1:0] x_fin;
  logic [POS_W-1:0] y_fin;

  assign in_stall = div_busy | (out_valid & out_stall);
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    third_prod = {{(PROD_W-POS_W){1'b0}}, screen_width} * THIRD_MUL;
    third      = POS_W'(third_prod[PROD_W-1:THIRD_SHIFT]);
    limit      = (screen_height > POS_W'(BOTTOM_MARGIN)) ?
                 screen_height - POS_W'(BOTTOM_MARGIN) : '0;
    width13    = {1'b0, screen_width};
    limit13    = {1'b0, limit};
  end

  always_comb begin
    // message start latches the column before anything else
    lsx_eff = in_data.message_start ? cursor_x : line_start_x;

    // newline: down one line, back to the start column, shift near bottom
    y_nl     = {1'b0, cursor_y} + SUM_W'(LINE_HEIGHT);
    shift_nl = {1'b0, lsx_eff} + {1'b0, third};
    if (y_nl >= limit13) begin
      x_nl = (shift_nl >= width13) ? '0 : shift_nl[POS_W-1:0];
    end else begin
      x_nl = lsx_eff;
    end

    // glyph: advance, wrap to a new line at the right edge
    x_adv    = {1'b0, cursor_x} + SUM_W'(GLYPH_WIDTH);
    col_wrap = (x_adv >= width13);
    y_gl     = col_wrap ? {1'b0, cursor_y} + SUM_W'(LINE_HEIGHT) : {1'b0, cursor_y};
    if (!col_wrap) begin
      x_gl = x_adv[POS_W-1:0];
    end else if (y_gl >= limit13) begin
      x_gl = ({1'b0, third} >= width13) ? '0 : third;
    end else begin
      x_gl = '0;
    end

    // backspace: step back one glyph if there is room
    x_bs = (cursor_x >= POS_W'(GLYPH_WIDTH)) ? cursor_x - POS_W'(GLYPH_WIDTH) : cursor_x;

    out_next.draw_y     = cursor_y;
    out_next.fore_color = fore_color_reg;
    out_next.back_color = back_color_reg;
    out_next.draw_x     = cursor_x;
    out_next.glyph      = in_data.char_code;
    emit     = 1'b1;
    x_new    = cursor_x;
    y_new    = cursor_y;
    mod_en   = 1'b0;
    mod_to_y = 1'b1;
    mod_a    = '0;
    mod_m    = screen_height;

    unique case (in_data.char_code)
      CHAR_NL: begin
        emit     = 1'b0;
        x_new    = x_nl;
        mod_en   = 1'b1;
        mod_to_y = 1'b1;
        mod_a    = y_nl;
        mod_m    = screen_height;
      end
      CHAR_TAB: begin
        emit     = 1'b0;
        y_new    = '0;
        mod_en   = 1'b1;
        mod_to_y = 1'b0;
        mod_a    = {1'b0, cursor_x} + SUM_W'(TAB_STEP);
        mod_m    = screen_width;
      end
      CHAR_BS: begin
        out_next.draw_x = x_bs;
        out_next.glyph  = CHAR_SPACE;
        x_new           = x_bs;
      end
      default: begin
        x_new    = x_gl;
        mod_en   = 1'b1;
        mod_to_y = 1'b1;
        mod_a    = y_gl;
        mod_m    = limit;
      end
    endcase
  end

  // one compare and subtract covers a dividend below twice the modulus
  always_comb begin
    mod_m13  = {1'b0, mod_m};
    mod_diff = mod_a - mod_m13;
    mod_fast = 1'b1;
    mod_res  = '0;
    if (mod_m == '0) begin
      mod_res = '0;
    end else if (mod_a < mod_m13) begin
      mod_res = mod_a[POS_W-1:0];
    end else if (mod_diff < mod_m13) begin
      mod_res = mod_diff[POS_W-1:0];
    end else begin
      mod_fast = 1'b0;
    end
    x_fin = (mod_en && !mod_to_y) ? mod_res : x_new;
    y_fin = (mod_en &&  mod_to_y) ? mod_res : y_new;
  end

  // restoring remainder step, one dividend bit per cycle
  always_comb begin
    div_trial    = {div_rem, div_num[SUM_W-1]};
    div_rem_next = (div_trial >= {1'b0, div_mod}) ? div_trial - {1'b0, div_mod} : div_trial;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width   <= WIDTH_RESET;
      screen_height  <= HEIGHT_RESET;
      fore_color_reg <= FORE_RESET;
      back_color_reg <= BACK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCREEN_WIDTH:  screen_width   <= cfg_data[POS_W-1:0];
        CFG_SCREEN_HEIGHT: screen_height  <= cfg_data[POS_W-1:0];
        CFG_FORE_COLOR:    fore_color_reg <= cfg_data;
        CFG_BACK_COLOR:    back_color_reg <= cfg_data;
        default: ;
      endcase
    end
  end

  // cursor and remainder unit control
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x     <= '0;
      cursor_y     <= '0;
      line_start_x <= '0;
      div_busy     <= 1'b0;
    end else if (accept) begin
      line_start_x <= lsx_eff;
      cursor_x     <= x_fin;
      cursor_y     <= y_fin;
      // slow wrap: remainder unit fills in the wrapped coordinate later
      div_busy     <= mod_en & ~mod_fast;
    end else if (div_busy && div_cnt == '0) begin
      div_busy <= 1'b0;
      if (div_to_y) begin
        cursor_y <= div_rem_next[POS_W-1:0];
      end else begin
        cursor_x <= div_rem_next[POS_W-1:0];
      end
    end
  end

  // remainder unit datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      div_cnt  <= DIV_LAST;
      div_num  <= mod_a;
      div_rem  <= '0;
      div_mod  <= mod_m;
      div_to_y <= mod_to_y;
    end else if (div_busy) begin
      div_cnt <= div_cnt - DIV_CNT_W'(1);
      div_num <= {div_num[SUM_W-2:0], 1'b0};
      div_rem <= div_rem_next[POS_W-1:0];
    end
  end

  // output register: draw transaction waits here while out is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= accept & emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_data <= out_next;
    end
  end

endmodule

`default_nettype wire
